// ===== design/mdm_pkg.sv =====
package mdm_pkg;

	localparam int ROM_BYTES_DEF = 4096;
	localparam int RAM_DEPTH     = 128;
	localparam int NUM_SFR       = 21;
	localparam int SFR_IW        = $clog2(NUM_SFR + 1);
	localparam int SUM_W         = 17;

	localparam logic [SFR_IW-1:0] SFR_SP   = SFR_IW'(1);
	localparam logic [SFR_IW-1:0] SFR_NONE = SFR_IW'(NUM_SFR);

	localparam logic [2:0] CMD_CODE_READ  = 3'd0;
	localparam logic [2:0] CMD_DATA_READ  = 3'd1;
	localparam logic [2:0] CMD_DATA_WRITE = 3'd2;
	localparam logic [2:0] CMD_PUSH_BYTE  = 3'd3;
	localparam logic [2:0] CMD_POP_BYTE   = 3'd4;
	localparam logic [2:0] CMD_PUSH_WORD  = 3'd5;
	localparam logic [2:0] CMD_POP_WORD   = 3'd6;
	localparam logic [2:0] CMD_LOAD_CODE  = 3'd7;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [7:0] SFR_BASE   = 8'h80;
	localparam logic [7:0] BYTE_ONES  = 8'hFF;
	localparam logic [7:0] SP_RESET   = 8'h07;

	// P0 SP DPL DPH PCON TCON TMOD TL0 TL1 TH0 TH1 P1 SCON SBUF P2 IE P3 IP PSW ACC B
	localparam logic [7:0] SFR_ADDR [NUM_SFR] = '{
		8'h80, 8'h81, 8'h82, 8'h83, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D,
		8'h90, 8'h98, 8'h99, 8'hA0, 8'hA8, 8'hB0, 8'hB8, 8'hD0, 8'hE0, 8'hF0
	};

	localparam logic [7:0] SFR_RST [NUM_SFR] = '{
		8'hFF, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00
	};

	function automatic logic [SFR_IW-1:0] sfr_index(input logic [7:0] a);
		logic [SFR_IW-1:0] idx;
		idx = SFR_NONE;
		for (int i = 0; i < NUM_SFR; i++) begin
			if (SFR_ADDR[i] == a) begin
				idx = SFR_IW'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== design/mdm_ram.sv =====
module mdm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/mcu_data_memory_sfr_stack_core.sv =====
// States per item: S_OP then S_DONE for data write, push byte and code load; S_OP, S_RD,
// S_DONE for code read, data read and pop byte; S_OP, S_OP2, S_DONE for push word; and
// S_OP, S_OP2, S_RD, S_DONE for pop word, set by the single registered RAM read port. One item
// at a time: the next item is taken the cycle after the result is registered, S_DONE holding while the output stalls.
// Reset (async, active low): SP 0x07, ports 0xFF, other SFRs 0, then a clearing pass
// over every ROM address zeroes ROM and RAM, during which cmd_stall stays high.
module mcu_data_memory_sfr_stack_core #(
	parameter int ROM_BYTES = mdm_pkg::ROM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [2:0]  cmd,
	input  logic [15:0] address,
	input  logic [15:0] value,
	input  logic [15:0] length,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [15:0] read_value,
	output logic [1:0]  status
);

	localparam int ROM_AW = $clog2(ROM_BYTES);
	localparam int RAM_AW = $clog2(mdm_pkg::RAM_DEPTH);
	localparam int SW     = mdm_pkg::SUM_W;
	localparam int IW     = mdm_pkg::SFR_IW;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_OP, S_OP2, S_RD, S_DONE
	} state_t;

	typedef enum logic [1:0] {
		SRC_HOLD, SRC_RAM, SRC_ROM
	} src_t;

	state_t            state_q;
	src_t              rd_src_q;
	logic [ROM_AW-1:0] clr_q;
	logic [ROM_AW-1:0] ld_off_q;
	logic [2:0]        cmd_q;
	logic [15:0]       addr_q;
	logic [15:0]       val_q;
	logic [15:0]       len_q;
	logic [7:0]        rd_hold_q;
	logic [7:0]        hi_q;
	logic [15:0]       res_q;
	logic [1:0]        st_q;
	logic              rsp_valid_q;
	logic [15:0]       read_value_q;
	logic [1:0]        status_q;
	logic [7:0]        sfr_q [mdm_pkg::NUM_SFR];

	logic [7:0]        sp, sp_inc, sp_dec, sp_new;
	logic              sp_upd;
	logic [7:0]        dmem_addr, acc_wdata;
	logic              acc_wr, acc_rd;
	logic [IW-1:0]     acc_idx;
	logic              sfr_hit, sfr_we;
	logic [7:0]        rd_byte;
	logic              clearing;

	logic              ram_we;
	logic [RAM_AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;
	logic              rom_we;
	logic [ROM_AW-1:0] rom_waddr, rom_raddr;
	logic [7:0]        rom_wdata, rom_rdata;

	logic              len_zero, ld_over, ld_ok, code_in_rom;
	logic [SW-1:0]     ld_sum;
	logic [ROM_AW-1:0] off_cur, ld_dst, off_next;
	logic [ROM_AW:0]   off_inc;
	logic              out_free;

	assign sp       = sfr_q[mdm_pkg::SFR_SP];
	assign sp_inc   = sp + 8'd1;
	assign sp_dec   = sp - 8'd1;
	assign clearing = (state_q == S_CLEAR);
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign len_zero    = (len_q == 16'd0);
	assign ld_sum      = {1'b0, addr_q} + {1'b0, len_q};
	assign ld_over     = ld_sum > SW'(ROM_BYTES);
	assign ld_ok       = !len_zero && !ld_over;
	assign off_cur     = (SW'(ld_off_q) >= SW'(len_q)) ? '0 : ld_off_q;
	assign ld_dst      = addr_q[ROM_AW-1:0] + off_cur;
	assign off_inc     = {1'b0, off_cur} + (ROM_AW+1)'(1);
	assign off_next    = (SW'(off_inc) >= SW'(len_q)) ? '0 : off_inc[ROM_AW-1:0];
	assign code_in_rom = {1'b0, addr_q} < SW'(ROM_BYTES);

	always_comb begin
		dmem_addr = sp;
		acc_wdata = val_q[7:0];
		acc_wr    = 1'b0;
		acc_rd    = 1'b0;
		sp_upd    = 1'b0;
		sp_new    = sp;
		case (state_q)
			S_OP: begin
				case (cmd_q)
					mdm_pkg::CMD_DATA_READ: begin
						dmem_addr = addr_q[7:0];
						acc_rd    = 1'b1;
					end
					mdm_pkg::CMD_DATA_WRITE: begin
						dmem_addr = addr_q[7:0];
						acc_wr    = 1'b1;
					end
					mdm_pkg::CMD_PUSH_BYTE, mdm_pkg::CMD_PUSH_WORD: begin
						dmem_addr = sp_inc;
						acc_wr    = 1'b1;
						sp_upd    = 1'b1;
						sp_new    = sp_inc;
					end
					mdm_pkg::CMD_POP_BYTE, mdm_pkg::CMD_POP_WORD: begin
						acc_rd = 1'b1;
						sp_upd = 1'b1;
						sp_new = sp_dec;
					end
					default: begin
					end
				endcase
			end
			S_OP2: begin
				if (cmd_q == mdm_pkg::CMD_PUSH_WORD) begin
					dmem_addr = sp_inc;
					acc_wdata = val_q[15:8];
					acc_wr    = 1'b1;
					sp_upd    = 1'b1;
					sp_new    = sp_inc;
				end else begin
					acc_rd = 1'b1;
					sp_upd = 1'b1;
					sp_new = sp_dec;
				end
			end
			default: begin
			end
		endcase
	end

	assign acc_idx = mdm_pkg::sfr_index(dmem_addr);
	assign sfr_hit = (acc_idx != mdm_pkg::SFR_NONE);
	assign sfr_we  = acc_wr && dmem_addr[7] && sfr_hit;

	assign ram_we    = clearing || (acc_wr && !dmem_addr[7]);
	assign ram_waddr = clearing ? clr_q[RAM_AW-1:0] : dmem_addr[RAM_AW-1:0];
	assign ram_wdata = clearing ? 8'h00 : acc_wdata;
	assign ram_raddr = dmem_addr[RAM_AW-1:0];

	assign rom_we    = clearing ||
		(state_q == S_OP && cmd_q == mdm_pkg::CMD_LOAD_CODE && ld_ok);
	assign rom_waddr = clearing ? clr_q : ld_dst;
	assign rom_wdata = clearing ? 8'h00 : val_q[7:0];
	assign rom_raddr = addr_q[ROM_AW-1:0];

	always_comb begin
		case (rd_src_q)
			SRC_RAM: rd_byte = ram_rdata;
			SRC_ROM: rd_byte = rom_rdata;
			default: rd_byte = rd_hold_q;
		endcase
	end

	mdm_ram #(.WIDTH(8), .DEPTH(mdm_pkg::RAM_DEPTH)) u_data_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mdm_ram #(.WIDTH(8), .DEPTH(ROM_BYTES)) u_code_rom (
		.clk   (clk),
		.we    (rom_we),
		.waddr (rom_waddr),
		.wdata (rom_wdata),
		.raddr (rom_raddr),
		.rdata (rom_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			ld_off_q    <= '0;
			rd_src_q    <= SRC_HOLD;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < mdm_pkg::NUM_SFR; i++) begin
				sfr_q[i] <= mdm_pkg::SFR_RST[i];
			end
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			if (acc_rd) begin
				rd_src_q  <= dmem_addr[7] ? SRC_HOLD : SRC_RAM;
				rd_hold_q <= sfr_hit ? sfr_q[acc_idx] : mdm_pkg::BYTE_ONES;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ROM_AW'(1);
					if (clr_q == ROM_AW'(ROM_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						addr_q  <= address;
						val_q   <= value;
						len_q   <= length;
						state_q <= S_OP;
					end
				end
				S_OP: begin
					res_q <= 16'h0000;
					st_q  <= mdm_pkg::ST_OK;
					case (cmd_q)
						mdm_pkg::CMD_CODE_READ: begin
							rd_src_q  <= code_in_rom ? SRC_ROM : SRC_HOLD;
							rd_hold_q <= mdm_pkg::BYTE_ONES;
							state_q   <= S_RD;
						end
						mdm_pkg::CMD_DATA_READ, mdm_pkg::CMD_POP_BYTE: begin
							state_q <= S_RD;
						end
						mdm_pkg::CMD_PUSH_WORD, mdm_pkg::CMD_POP_WORD: begin
							state_q <= S_OP2;
						end
						mdm_pkg::CMD_LOAD_CODE: begin
							if (len_zero) begin
								st_q     <= mdm_pkg::ST_EMPTY;
								ld_off_q <= '0;
							end else if (ld_over) begin
								st_q     <= mdm_pkg::ST_RANGE;
								ld_off_q <= '0;
							end else begin
								ld_off_q <= off_next;
							end
							state_q <= S_DONE;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_OP2: begin
					hi_q    <= rd_byte;
					state_q <= (cmd_q == mdm_pkg::CMD_POP_WORD) ? S_RD : S_DONE;
				end
				S_RD: begin
					res_q   <= (cmd_q == mdm_pkg::CMD_POP_WORD) ? {hi_q, rd_byte}
						: {8'h00, rd_byte};
					st_q    <= mdm_pkg::ST_OK;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						read_value_q <= res_q;
						status_q     <= st_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// a stack write that lands on SP itself takes priority over the SP step
			for (int i = 0; i < mdm_pkg::NUM_SFR; i++) begin
				if (sfr_we && acc_idx == IW'(i)) begin
					sfr_q[i] <= acc_wdata;
				end else if (sp_upd && IW'(i) == mdm_pkg::SFR_SP) begin
					sfr_q[i] <= sp_new;
				end
			end
		end
	end

	assign cmd_stall  = (state_q != S_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

endmodule

// ===== design/mdm_checker.sv =====
module mdm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [15:0] read_value,
	input logic [1:0]  status
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(read_value) && $stable(status))
		else $error("stalled result changed");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("second item taken while one is in flight");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != mdm_pkg::ST_OK |-> read_value == 16'h0000)
		else $error("load error carries read data");

	a_rsp_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd_stall))
		else $error("result without an item in flight");

endmodule

bind mcu_data_memory_sfr_stack_core mdm_checker u_mdm_checker (.*);
